// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define SFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sfd_pkg.sv =====
// Constants and types of the SBUS frame decoder
package sfd_pkg;

    localparam int unsigned NUM_CHAN   = 16;
    localparam int unsigned CHAN_W     = 11;
    localparam int unsigned NUM_DATA   = 22;
    localparam int unsigned IDX_W      = 4;
    localparam int unsigned POS_W      = 5;
    localparam int unsigned FRAME_W    = NUM_DATA * 8;

    localparam logic [7:0] START_BYTE  = 8'h0F;
    localparam logic [7:0] END_BYTE    = 8'h00;

    localparam logic [POS_W-1:0] POS_FIRST_DATA = 5'd1;
    localparam logic [POS_W-1:0] POS_LAST_DATA  = 5'd22;
    localparam logic [POS_W-1:0] POS_FLAG       = 5'd23;
    localparam logic [POS_W-1:0] POS_END        = 5'd24;

    localparam logic [CHAN_W-1:0] CH6_REMOTE    = 11'd201;
    localparam logic [CHAN_W-1:0] CH10_ALT      = 11'd1801;
    localparam logic [CHAN_W-1:0] CENTER_RESET  = 11'd1024;

    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_REMOTE = 2'd1;
    localparam logic [1:0] MODE_ALT    = 2'd2;

    localparam logic [IDX_W-1:0] LAST_IDX = 4'd15;

    typedef logic [CHAN_W-1:0] t_chan;

endpackage

// ===== rtl/core/sbus_frame_decoder_core.sv =====
// SBUS frame decoder: takes one received byte per cycle; a 0x0F byte opens a 25-byte
// frame and a 0x00 end byte releases its sixteen 11-bit channels as sixteen result
// items, one per cycle unless i_out_stall holds them, from a channel buffer behind the
// output register. Input bytes are taken every cycle while results drain; only the end
// byte of a following frame is stalled until the buffer has handed its last item to
// the output register, so the bytes of one frame and the results of the last overlap.
module sbus_frame_decoder_core
    import sfd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [7:0]          i_rx_byte,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [3:0]          o_channel_index,
    output logic [10:0]         o_channel_value,
    output logic signed [11:0]  o_left_speed,
    output logic signed [12:0]  o_right_speed,
    output logic [1:0]          o_control_mode,
    output logic                o_last_channel,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [7:0]        r_frame [NUM_DATA];
    logic [POS_W-1:0]  r_pos;
    logic              r_in_frame;
    logic [1:0]        r_mode;
    logic [CHAN_W-1:0] r_center;

    t_chan             r_ch [NUM_CHAN];
    logic              r_busy;
    logic [IDX_W-1:0]  r_idx;
    logic [11:0]       r_left;
    logic [12:0]       r_right;

    logic              in_acc;
    logic              is_start;
    logic              frame_done;
    logic              out_ready;
    logic [FRAME_W-1:0] frame_vec;
    t_chan             chans [NUM_CHAN];
    logic [1:0]        n_mode;
    logic [11:0]       n_left;
    logic [12:0]       n_right;

    assign pready     = 1'b1;
    assign prdata     = paddr[2] ? 32'd0 : {21'd0, r_center};

    assign o_in_stall = r_busy && r_in_frame && (r_pos == POS_END);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign is_start   = (i_rx_byte == START_BYTE);
    assign frame_done = in_acc && !is_start && r_in_frame && (r_pos == POS_END)
                        && (i_rx_byte == END_BYTE);
    assign out_ready  = !o_out_valid || !i_out_stall;

    always_comb begin
        for (int i = 0; i < NUM_DATA; i++) begin
            frame_vec[8*i +: 8] = r_frame[i];
        end
        for (int k = 0; k < NUM_CHAN; k++) begin
            chans[k] = frame_vec[CHAN_W*k +: CHAN_W];
        end
    end

    always_comb begin
        n_left  = {1'b0, chans[0]} - {1'b0, chans[1]};
        n_right = {2'b00, chans[0]} + {2'b00, chans[1]} - {1'b0, r_center, 1'b0};
        if (chans[5] == CH6_REMOTE) begin
            n_mode = MODE_REMOTE;
        end else if (chans[9] == CH10_ALT) begin
            n_mode = MODE_ALT;
        end else if (r_mode == MODE_ALT) begin
            n_mode = MODE_ALT;
        end else begin
            n_mode = MODE_NONE;
        end
    end

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= CENTER_RESET;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_center <= pwdata[CHAN_W-1:0];
        end
    end

    // frame capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_in_frame <= 1'b0;
            r_mode     <= MODE_NONE;
        end else if (in_acc) begin
            if (is_start) begin
                r_in_frame <= 1'b1;
                r_pos      <= POS_FIRST_DATA;
            end else if (r_in_frame) begin
                if (r_pos >= POS_FIRST_DATA && r_pos <= POS_FLAG) begin
                    r_pos <= r_pos + 5'd1;
                end else begin
                    r_in_frame <= 1'b0;
                    r_pos      <= '0;
                    if (i_rx_byte == END_BYTE) begin
                        r_mode <= n_mode;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && !is_start && r_in_frame) begin
            for (int i = 0; i < NUM_DATA; i++) begin
                if (r_pos == POS_W'(i + 1)) begin
                    r_frame[i] <= i_rx_byte;
                end
            end
        end
    end

    // channel buffer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (frame_done) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (r_busy && out_ready) begin
                r_idx <= r_idx + 4'd1;
                if (r_idx == LAST_IDX) begin
                    r_busy <= 1'b0;
                end
            end
            if (out_ready) begin
                o_out_valid <= r_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (frame_done) begin
            for (int k = 0; k < NUM_CHAN; k++) begin
                r_ch[k] <= chans[k];
            end
            r_left  <= n_left;
            r_right <= n_right;
        end
        if (r_busy && out_ready) begin
            o_channel_index <= r_idx;
            o_channel_value <= r_ch[r_idx];
            o_left_speed    <= r_left;
            o_right_speed   <= r_right;
            o_control_mode  <= r_mode;
            o_last_channel  <= (r_idx == LAST_IDX);
        end
    end

endmodule

// ===== rtl/core/sfd_checker.sv =====
// Port-level checker for the SBUS frame decoder, bound to sbus_frame_decoder_core
`include "assert_macros.svh"

module sfd_port_asserts (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [3:0]         o_channel_index,
    input logic signed [11:0] o_left_speed,
    input logic signed [12:0] o_right_speed,
    input logic [1:0]         o_control_mode,
    input logic               o_last_channel
);

    logic        last_out;
    logic        mid_acc;
    logic        idx_ok;
    logic [3:0]  r_exp_idx;
    logic [26:0] frame_flds;

    assign last_out   = o_out_valid && o_last_channel;
    assign mid_acc    = o_out_valid && !i_out_stall && !o_last_channel;
    assign idx_ok     = o_out_valid && (o_channel_index == r_exp_idx);
    assign frame_flds = {o_left_speed, o_right_speed, o_control_mode};

    always_ff @(posedge i_clk) begin
        r_exp_idx <= o_channel_index + 4'd1;
    end

    `SFD_ASSERT_NOW(a_last_is_ch16, last_out, o_channel_index == 4'd15, "last item not ch16")

    `SFD_ASSERT_NEXT(a_next_chan, mid_acc, idx_ok, "channel items not consecutive")

    `SFD_ASSERT_NEXT(a_frame_fields, mid_acc, $stable(frame_flds), "frame-wide fields changed")

    `SFD_ASSERT_NOW(a_stall_only_draining, o_in_stall, o_out_valid, "stall while idle")

endmodule

bind sbus_frame_decoder_core sfd_port_asserts u_sfd_checker (.*);
